[src/thi_pkg.sv]
// shared types for the triangle height interpolator
// no dependencies
package thi_pkg;

  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
    logic deg;
  } flags_t;

endpackage

[src/thi_front.sv]
// front pipeline: edge vectors, cross products, determinant and numerator
// five register stages, advances when en is high; no package dependency
module thi_front #(
  parameter int C = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [C-1:0]     v0_x,
  input  logic signed [C-1:0]     v0_y,
  input  logic signed [C-1:0]     v0_z,
  input  logic signed [C-1:0]     v1_x,
  input  logic signed [C-1:0]     v1_y,
  input  logic signed [C-1:0]     v1_z,
  input  logic signed [C-1:0]     v2_x,
  input  logic signed [C-1:0]     v2_y,
  input  logic signed [C-1:0]     v2_z,
  input  logic signed [C-1:0]     query_x,
  input  logic signed [C-1:0]     query_y,
  output logic                    valid_o,
  output logic signed [3*C+4:0]   num_o,
  output logic signed [2*C+2:0]   det_o,
  output logic signed [C-1:0]     z0_o
);

  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int WW = PW + 1;
  localparam int LB = C + 1;
  localparam int HB = WW - LB;
  localparam int NW = 3 * C + 5;

  // stage 1: differences
  logic                 s1_valid;
  logic signed [DW-1:0] ax, ay, bx, by, hx, hy, dz1, dz2;
  logic signed [C-1:0]  s1_z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax    <= DW'(v0_x) - DW'(v1_x);
      ay    <= DW'(v0_y) - DW'(v1_y);
      bx    <= DW'(v0_x) - DW'(v2_x);
      by    <= DW'(v0_y) - DW'(v2_y);
      hx    <= DW'(v0_x) - DW'(query_x);
      hy    <= DW'(v0_y) - DW'(query_y);
      dz1   <= DW'(v1_z) - DW'(v0_z);
      dz2   <= DW'(v2_z) - DW'(v0_z);
      s1_z0 <= v0_z;
    end
  end

  // stage 2: cross products
  logic                 s2_valid;
  logic signed [PW-1:0] p_aby, p_bay, p_byhx, p_bxhy, p_axhy, p_ayhx;
  logic signed [DW-1:0] s2_dz1, s2_dz2;
  logic signed [C-1:0]  s2_z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_aby  <= ax * by;
      p_bay  <= bx * ay;
      p_byhx <= by * hx;
      p_bxhy <= bx * hy;
      p_axhy <= ax * hy;
      p_ayhx <= ay * hx;
      s2_dz1 <= dz1;
      s2_dz2 <= dz2;
      s2_z0  <= s1_z0;
    end
  end

  // stage 3: determinant and weights
  logic                 s3_valid;
  logic signed [WW-1:0] det, wy, wz;
  logic signed [DW-1:0] s3_dz1, s3_dz2;
  logic signed [C-1:0]  s3_z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det    <= WW'(p_aby) - WW'(p_bay);
      wy     <= WW'(p_byhx) - WW'(p_bxhy);
      wz     <= WW'(p_axhy) - WW'(p_ayhx);
      s3_dz1 <= s2_dz1;
      s3_dz2 <= s2_dz2;
      s3_z0  <= s2_z0;
    end
  end

  // stage 4: split partial products of weight times height step
  logic                    s4_valid;
  logic signed [LB+DW:0]   ml1, ml2;
  logic signed [HB+DW-1:0] mh1, mh2;
  logic signed [WW-1:0]    s4_det;
  logic signed [C-1:0]     s4_z0;
  logic signed [HB-1:0]    wy_hi, wz_hi;
  logic signed [LB:0]      wy_lo, wz_lo;

  assign wy_hi = wy[WW-1:LB];
  assign wz_hi = wz[WW-1:LB];
  assign wy_lo = $signed({1'b0, wy[LB-1:0]});
  assign wz_lo = $signed({1'b0, wz[LB-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ml1    <= wy_lo * s3_dz1;
      mh1    <= wy_hi * s3_dz1;
      ml2    <= wz_lo * s3_dz2;
      mh2    <= wz_hi * s3_dz2;
      s4_det <= det;
      s4_z0  <= s3_z0;
    end
  end

  // stage 5: numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o <= (NW'(mh1) <<< LB) + NW'(ml1) + (NW'(mh2) <<< LB) + NW'(ml2);
      det_o <= s4_det;
      z0_o  <= s4_z0;
    end
  end

endmodule

[src/thi_div_step.sv]
// one registered step of the restoring divider, one quotient bit per stage
// depends on thi_pkg for the flag struct
module thi_div_step #(
  parameter int C  = 24,
  parameter int Q  = 26,
  parameter int WW = 51,
  parameter int RW = 52
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  thi_pkg::flags_t   f_i,
  input  logic [RW-1:0]     r_i,
  input  logic [Q-1:0]      n_i,
  input  logic [Q-1:0]      q_i,
  input  logic [WW-1:0]     d_i,
  input  logic [C-1:0]      z0_i,
  output thi_pkg::flags_t   f_o,
  output logic [RW-1:0]     r_o,
  output logic [Q-1:0]      n_o,
  output logic [Q-1:0]      q_o,
  output logic [WW-1:0]     d_o,
  output logic [C-1:0]      z0_o
);

  logic [RW-1:0] t;
  logic [RW-1:0] dx;
  logic          ge;

  assign t  = {r_i[RW-2:0], n_i[Q-1]};
  assign dx = RW'(d_i);
  assign ge = (t >= dx);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_o <= '0;
    end else if (en) begin
      f_o <= f_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_o  <= ge ? (t - dx) : t;
      q_o  <= {q_i[Q-2:0], ge};
      n_o  <= {n_i[Q-2:0], 1'b0};
      d_o  <= d_i;
      z0_o <= z0_i;
    end
  end

endmodule

[src/triangle_height_interpolator.sv]
// Interpolated terrain height at a query point from the three vertices of a
// triangle. Fully pipelined: a new item is taken every cycle unless in_stall
// is high; the path runs through five arithmetic stages, one sign stage,
// COORD_BITS + 2 restoring divider steps, a rounding stage and the output
// register. The whole pipeline holds while a valid output is stalled.
// Top level; depends on thi_pkg, thi_front and thi_div_step.
module triangle_height_interpolator #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] v0_x,
  input  logic signed [COORD_BITS-1:0] v0_y,
  input  logic signed [COORD_BITS-1:0] v0_z,
  input  logic signed [COORD_BITS-1:0] v1_x,
  input  logic signed [COORD_BITS-1:0] v1_y,
  input  logic signed [COORD_BITS-1:0] v1_z,
  input  logic signed [COORD_BITS-1:0] v2_x,
  input  logic signed [COORD_BITS-1:0] v2_y,
  input  logic signed [COORD_BITS-1:0] v2_z,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] height,
  output logic                         degenerate
);

  localparam int C  = COORD_BITS;
  localparam int WW = 2 * C + 3;
  localparam int NW = 3 * C + 5;
  localparam int Q  = C + 2;
  localparam int RW = WW + 1;
  localparam int SW = Q + 2;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic                 f_valid;
  logic signed [NW-1:0] f_num;
  logic signed [WW-1:0] f_det;
  logic signed [C-1:0]  f_z0;

  thi_front #(.C(C)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .query_x(query_x), .query_y(query_y),
    .valid_o(f_valid), .num_o(f_num), .det_o(f_det), .z0_o(f_z0)
  );

  // sign stage: magnitudes, overflow check, divider seed
  logic [NW-1:0] nabs;
  logic [WW-1:0] dabs;
  logic [NW-1:0] nhi;

  assign nabs = f_num[NW-1] ? NW'(-f_num) : NW'(f_num);
  assign dabs = f_det[WW-1] ? WW'(-f_det) : WW'(f_det);
  assign nhi  = nabs >> Q;

  thi_pkg::flags_t f [0:Q];
  logic [RW-1:0]   r [0:Q];
  logic [Q-1:0]    n [0:Q];
  logic [Q-1:0]    q [0:Q];
  logic [WW-1:0]   d [0:Q];
  logic [C-1:0]    z [0:Q];

  always_ff @(posedge clk) begin
    if (rst) begin
      f[0] <= '0;
    end else if (en) begin
      f[0].valid <= f_valid;
      f[0].neg   <= f_num[NW-1] ^ f_det[WW-1];
      f[0].ovf   <= (nhi >= NW'(dabs));
      f[0].deg   <= (f_det == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= nhi[RW-1:0];
      n[0] <= nabs[Q-1:0];
      q[0] <= '0;
      d[0] <= dabs;
      z[0] <= f_z0;
    end
  end

  for (genvar i = 0; i < Q; i++) begin : g_div
    thi_div_step #(.C(C), .Q(Q), .WW(WW), .RW(RW)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .f_i(f[i]), .r_i(r[i]), .n_i(n[i]), .q_i(q[i]), .d_i(d[i]), .z0_i(z[i]),
      .f_o(f[i+1]), .r_o(r[i+1]), .n_o(n[i+1]), .q_o(q[i+1]), .d_o(d[i+1]),
      .z0_o(z[i+1])
    );
  end

  // rounding stage, ties away from zero
  thi_pkg::flags_t rf;
  logic [Q:0]      rq;
  logic [C-1:0]    rz;
  logic            up;

  assign up = ({r[Q], 1'b0} >= (RW + 1)'(d[Q]));

  always_ff @(posedge clk) begin
    if (rst) begin
      rf <= '0;
    end else if (en) begin
      rf <= f[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rq <= {1'b0, q[Q]} + (Q + 1)'(up);
      rz <= z[Q];
    end
  end

  // output stage: apply sign, add base height, clamp, zero height when degenerate
  logic signed [SW-1:0] sq;
  logic signed [SW-1:0] hs;
  logic signed [SW-1:0] hmax;
  logic signed [SW-1:0] hmin;
  logic signed [C-1:0]  hc;

  assign hmax = SW'({1'b0, {(C-1){1'b1}}});
  assign hmin = -(SW'(1) <<< (C - 1));
  assign sq   = rf.neg ? -$signed(SW'(rq)) : $signed(SW'(rq));
  assign hs   = SW'($signed(rz)) + sq;

  always_comb begin
    if (rf.ovf) begin
      hc = rf.neg ? C'(hmin) : C'(hmax);
    end else if (hs > hmax) begin
      hc = C'(hmax);
    end else if (hs < hmin) begin
      hc = C'(hmin);
    end else begin
      hc = hs[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rf.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      height     <= rf.deg ? '0 : hc;
      degenerate <= rf.deg;
    end
  end

endmodule

[tb/tb.sv]
// self-checking testbench for triangle_height_interpolator: random and directed
// triangles, exact wide-integer height prediction, random idling on both sides
// depends on triangle_height_interpolator and the parts it instantiates
module tb;

  localparam int CB = 24;
  localparam int QUIET_LO = 700;
  localparam int QUIET_HI = 1000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 250;
  localparam int WATCHDOG = 5000;

  typedef struct packed {
    logic signed [CB-1:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic signed [CB-1:0] query_x, query_y;
  } tri_query_t;

  typedef struct packed {
    logic signed [CB-1:0] height;
    logic                 degenerate;
  } height_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 0;
  logic signed [CB-1:0] v0_x = 0, v0_y = 0, v0_z = 0, v1_x = 0, v1_y = 0, v1_z = 0;
  logic signed [CB-1:0] v2_x = 0, v2_y = 0, v2_z = 0, query_x = 0, query_y = 0;
  logic signed [CB-1:0] height;
  logic degenerate;

  tri_query_t pending_tris[$];
  height_t    expected_heights[$];
  int  errors = 0;
  int  sent = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  in_taken = 0;

  triangle_height_interpolator #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z), .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z), .query_x(query_x), .query_y(query_y),
    .out_valid(out_valid), .out_stall(out_stall), .height(height),
    .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  function automatic height_t interpolate_height(input tri_query_t t);
    logic signed [127:0] ax, ay, bx, by, hx, hy, det, wy, wz, num, q, h;
    logic [127:0] nm, dm, qu, rm;
    height_t r;
    ax = t.v0_x - t.v1_x;
    ay = t.v0_y - t.v1_y;
    bx = t.v0_x - t.v2_x;
    by = t.v0_y - t.v2_y;
    hx = t.v0_x - t.query_x;
    hy = t.v0_y - t.query_y;
    det = ax * by - bx * ay;
    r.height = '0;
    r.degenerate = 1'b1;
    if (det == 0) return r;
    wy = by * hx - bx * hy;
    wz = ax * hy - ay * hx;
    num = wy * (t.v1_z - t.v0_z) + wz * (t.v2_z - t.v0_z);
    nm = num < 0 ? -num : num;
    dm = det < 0 ? -det : det;
    qu = nm / dm;
    rm = nm % dm;
    if ((rm << 1) >= dm) qu = qu + 1;
    q = ((num < 0) != (det < 0)) ? -$signed(qu) : $signed(qu);
    h = q + t.v0_z;
    if (h > 128'sd8388607) h = 128'sd8388607;
    if (h < -128'sd8388608) h = -128'sd8388608;
    r.height = h[CB-1:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(input int span);
    if (span == 0) return $signed(CB'($urandom));
    return $signed(CB'($urandom_range(2 * span)) - CB'(span));
  endfunction

  function automatic tri_query_t make_tri(input int span);
    tri_query_t t;
    t.v0_x = rnd_coord(span); t.v0_y = rnd_coord(span); t.v0_z = rnd_coord(0);
    t.v1_x = rnd_coord(span); t.v1_y = rnd_coord(span); t.v1_z = rnd_coord(0);
    t.v2_x = rnd_coord(span); t.v2_y = rnd_coord(span); t.v2_z = rnd_coord(0);
    t.query_x = rnd_coord(span); t.query_y = rnd_coord(span);
    if ($urandom_range(3) == 0) begin
      t.v0_z = rnd_coord(span); t.v1_z = rnd_coord(span); t.v2_z = rnd_coord(span);
    end
    return t;
  endfunction

  function automatic tri_query_t tri_of(input int a, b, c, d, e, f, g, h, i, j, k);
    tri_query_t t;
    t = {CB'(a), CB'(b), CB'(c), CB'(d), CB'(e), CB'(f), CB'(g), CB'(h), CB'(i),
         CB'(j), CB'(k)};
    return t;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_taken) begin
      if (pending_tris.size() > 0 &&
          (($urandom_range(99) >= 31) || (sent >= QUIET_LO && sent < QUIET_HI))) begin
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, query_x, query_y}
          <= pending_tris.pop_front();
        in_valid <= 1;
        sent++;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else if (!hold_done && sent >= HOLD_AT) begin
      hold_done <= 1;
      hold_left <= HOLD_LEN;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < 31) && !(sent >= QUIET_LO && sent < QUIET_HI);
    end
  end

  // monitor
  always @(posedge clk) begin
    height_t got, exp_h;
    in_taken = in_valid && !in_stall && !rst;
    if (in_taken)
      expected_heights.push_back(interpolate_height(
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, query_x, query_y}));
    if (!rst && out_valid && !out_stall) begin
      got = {height, degenerate};
      if (expected_heights.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        exp_h = expected_heights.pop_front();
        if (got.height !== exp_h.height)
          report_mismatch($sformatf("height %0d, expected %0d", got.height, exp_h.height));
        if (got.degenerate !== exp_h.degenerate)
          report_mismatch($sformatf("degenerate %0b, expected %0b",
                                    got.degenerate, exp_h.degenerate));
      end
    end
    if (in_taken || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("triangle_height_interpolator regression: fail");
      $finish;
    end
  end

  initial begin
    int k, s;
    tri_query_t t;
    // directed: extremes, degenerate, rounding ties, saturation, outside query
    pending_tris.push_back(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(tri_of(0, 0, 5, 4, 4, 9, 8, 8, 1, 3, 3));
    pending_tris.push_back(tri_of(0, 0, 0, 2, 0, 1, 0, 2, 0, 1, 0));
    pending_tris.push_back(tri_of(0, 0, 0, 2, 0, -1, 0, 2, 0, 1, 0));
    pending_tris.push_back(tri_of(0, 0, 0, 2, 0, 3, 0, 2, 0, 1, 0));
    pending_tris.push_back(tri_of(0, 0, 0, 3, 0, 1, 0, 3, 0, 1, 0));
    pending_tris.push_back(tri_of(0, 0, 0, 3, 0, 2, 0, 3, 0, 2, 0));
    pending_tris.push_back(tri_of(0, 0, 0, 1, 0, 8388607, 0, 1, 0, 5, 0));
    pending_tris.push_back(tri_of(0, 0, 0, 1, 0, -8388608, 0, 1, 0, 5, 0));
    pending_tris.push_back(tri_of(-8388608, -8388608, -8388608, 8388607, -8388608,
                                  8388607, -8388608, 8388607, 8388607,
                                  8388607, 8388607));
    pending_tris.push_back(tri_of(8388607, 8388607, 8388607, -8388608, 8388607,
                                  -8388608, 8388607, -8388608, -8388608,
                                  -8388608, -8388608));
    pending_tris.push_back(tri_of(-8388608, 0, 100, 8388607, 0, -100, 0, 8388607, 0,
                                  -8388608, -8388608));
    pending_tris.push_back(tri_of(10, 10, 7, 20, 10, 7, 10, 20, 7, -5000, 9000));
    pending_tris.push_back(tri_of(1, 1, 1, 2, 2, 2, 3, 3, 3, 8388607, -8388608));
    pending_tris.push_back(tri_of(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_tris.push_back(tri_of(0, 0, 8388607, 1, 0, -8388608, 0, 1, -8388608,
                                  -8388608, -8388608));
    // random: mostly real triangles, some collinear, some tiny for ties
    for (k = 0; k < 1950; k++) begin
      s = $urandom_range(9);
      if (s < 4) t = make_tri(0);
      else if (s < 6) t = make_tri(1000);
      else if (s < 8) t = make_tri(4);
      else begin
        t = make_tri(2000);
        s = $urandom_range(2);
        t.v2_x = t.v0_x + CB'(s) * (t.v1_x - t.v0_x);
        t.v2_y = t.v0_y + CB'(s) * (t.v1_y - t.v0_y);
      end
      pending_tris.push_back(t);
    end
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (pending_tris.size() == 0);
    @(posedge clk);
    while (in_valid || expected_heights.size() > 0) @(posedge clk);
    repeat (CB + 30) @(posedge clk);
    if (errors == 0) begin
      $display("triangle_height_interpolator regression: pass");
    end else begin
      $display("triangle_height_interpolator regression: fail");
    end
    $finish;
  end

endmodule
